>>> rtl/mdrs_pkg.sv
// ----------------------------------------------------------------------------
// Rounded multiply-divide package
// Shared transfer types and constants for the rounded, saturating
// multiply-divide pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mdrs_pkg;

  // Operation codes carried in req_type.
  localparam logic [1:0] MODE_U8  = 2'd0;
  localparam logic [1:0] MODE_S8  = 2'd1;
  localparam logic [1:0] MODE_U16 = 2'd2;
  localparam logic [1:0] MODE_S16 = 2'd3;

  // Number of divider cells, one quotient bit each.
  localparam int unsigned NUM_CELLS = 16;

  // Range limits of the signed modes and the masks of the mode widths.
  localparam logic [15:0] SMAX_8  = 16'd127;
  localparam logic [15:0] SNEG_8  = 16'd128;
  localparam logic [15:0] SMAX_16 = 16'h7FFF;
  localparam logic [15:0] SNEG_16 = 16'h8000;
  localparam logic [15:0] MASK_8  = 16'h00FF;
  localparam logic [15:0] MASK_16 = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [15:0] divisor;
  } req_t;

  typedef struct packed {
    logic [15:0] quotient;
    logic        clipped;
    logic        zero_divisor;
  } res_t;

  // Token that travels down the divider chain.
  typedef struct packed {
    logic        wide;   // 16-bit mode
    logic        sgn;    // signed first factor
    logic        neg;    // first factor was negative
    logic        zero;   // divisor was zero
    logic        ovf;    // quotient does not fit in 16 bits
    logic [15:0] rem;    // partial remainder
    logic [15:0] low;    // dividend bits still to come, quotient bits shifted in
    logic [15:0] dvs;    // divisor of the mode width
  } div_tok_t;

endpackage

`default_nettype wire

>>> rtl/mdrs_front.sv
// ----------------------------------------------------------------------------
// Rounded multiply-divide front end
// Two stages: operand masking, magnitude and product; then the rounding
// bias and the overflow test that feed the divider chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdrs_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  mdrs_pkg::req_t        in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output mdrs_pkg::div_tok_t    out_tok
);

  // Stage A registers.
  logic        a_valid_r;
  logic        a_wide_r;
  logic        a_sgn_r;
  logic        a_neg_r;
  logic [31:0] a_prod_r;
  logic [15:0] a_dvs_r;
  logic        a_ready;

  // Stage B registers.
  logic               b_valid_r;
  mdrs_pkg::div_tok_t b_tok_r;
  logic               b_ready;

  // Stage A combinational terms.
  logic        wide;
  logic        sgn;
  logic [15:0] opa;
  logic [15:0] opb;
  logic [15:0] dvs;
  logic        neg;
  logic [15:0] mag;
  logic [31:0] prod;

  // Stage B combinational terms.
  logic [31:0]        sum;
  mdrs_pkg::div_tok_t tok;

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    wide = in_data.req_type[1];
    sgn  = in_data.req_type[0];
    opa  = wide ? in_data.operand_a : {8'h00, in_data.operand_a[7:0]};
    opb  = wide ? in_data.operand_b : {8'h00, in_data.operand_b[7:0]};
    dvs  = wide ? in_data.divisor   : {8'h00, in_data.divisor[7:0]};
    neg  = sgn && (wide ? opa[15] : opa[7]);
    // The most negative value keeps its full magnitude.
    if (!neg) begin
      mag = opa;
    end else if (wide) begin
      mag = 16'(~opa + 16'd1);
    end else begin
      mag = {8'h00, 8'(~opa[7:0] + 8'd1)};
    end
    prod = {16'h0000, mag} * {16'h0000, opb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_wide_r <= wide;
      a_sgn_r  <= sgn;
      a_neg_r  <= neg;
      a_prod_r <= prod;
      a_dvs_r  <= dvs;
    end
  end

  // The biased dividend cannot exceed 32 bits for any operand pattern.
  always_comb begin
    sum      = a_prod_r + {17'h00000, a_dvs_r[15:1]};
    tok.wide = a_wide_r;
    tok.sgn  = a_sgn_r;
    tok.neg  = a_neg_r;
    tok.zero = (a_dvs_r == 16'h0000);
    tok.ovf  = (sum[31:16] >= a_dvs_r);
    tok.rem  = sum[31:16];
    tok.low  = sum[15:0];
    tok.dvs  = a_dvs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r && b_ready) begin
      b_tok_r <= tok;
    end
  end

  assign out_valid = b_valid_r;
  assign out_tok   = b_tok_r;

endmodule

`default_nettype wire

>>> rtl/mdrs_cell.sv
// ----------------------------------------------------------------------------
// Rounded multiply-divide divider cell
// One restoring division step: shifts in a dividend bit, subtracts the
// divisor when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdrs_cell (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  mdrs_pkg::div_tok_t    in_tok,
  output logic                  out_valid,
  input  wire                   out_ready,
  output mdrs_pkg::div_tok_t    out_tok
);

  logic               valid_r;
  mdrs_pkg::div_tok_t tok_r;
  mdrs_pkg::div_tok_t tok_nxt;
  logic [16:0]        trial;
  logic [16:0]        diff;
  logic               fits;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    trial   = {in_tok.rem, in_tok.low[15]};
    diff    = trial - {1'b0, in_tok.dvs};
    fits    = (trial >= {1'b0, in_tok.dvs});
    tok_nxt = in_tok;
    tok_nxt.rem = fits ? diff[15:0] : trial[15:0];
    tok_nxt.low = {in_tok.low[14:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;

endmodule

`default_nettype wire

>>> rtl/mdrs_back.sv
// ----------------------------------------------------------------------------
// Rounded multiply-divide back end
// Saturates the quotient to the mode range, restores the sign, handles a
// zero divisor and holds the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdrs_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  mdrs_pkg::div_tok_t    in_tok,
  output logic                  out_valid,
  input  wire                   out_stall,
  output mdrs_pkg::res_t        out_data
);

  logic           valid_r;
  mdrs_pkg::res_t res_r;
  mdrs_pkg::res_t res_nxt;
  logic [15:0]    mask;
  logic [15:0]    smax;
  logic [15:0]    sneg;
  logic [15:0]    q;
  logic           clip;

  assign in_ready = !valid_r || !out_stall;

  always_comb begin
    mask = in_tok.wide ? mdrs_pkg::MASK_16 : mdrs_pkg::MASK_8;
    smax = in_tok.wide ? mdrs_pkg::SMAX_16 : mdrs_pkg::SMAX_8;
    sneg = in_tok.wide ? mdrs_pkg::SNEG_16 : mdrs_pkg::SNEG_8;
    q    = in_tok.low;
    clip = 1'b0;
    if (in_tok.ovf || (!in_tok.wide && (q[15:8] != 8'h00))) begin
      q    = mask;
      clip = 1'b1;
    end
    if (in_tok.sgn) begin
      if (!in_tok.neg) begin
        if (q > smax) begin
          q    = smax;
          clip = 1'b1;
        end
      end else begin
        if (q > sneg) begin
          q    = sneg;
          clip = 1'b1;
        end
        q = 16'(~q + 16'd1) & mask;
      end
    end
    if (in_tok.zero) begin
      res_nxt.quotient     = mask;
      res_nxt.clipped      = 1'b0;
      res_nxt.zero_divisor = 1'b1;
    end else begin
      res_nxt.quotient     = q;
      res_nxt.clipped      = clip;
      res_nxt.zero_divisor = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;

endmodule

`default_nettype wire

>>> rtl/mul_div_round_saturate.sv
// ----------------------------------------------------------------------------
// Rounded multiply-divide with saturation
// Computes a*b/d rounded to nearest in four unsigned and signed-by-unsigned
// modes, saturating to the mode range, as a fully pipelined unit.
// ----------------------------------------------------------------------------
// Throughput: one transfer per cycle while the output is not stalled; each of
// the 16 divider cells resolves one quotient bit and hands its partial
// remainder to the next cell.
// Reset: synchronous, active low; clears every stage valid bit, so the
// pipeline comes up empty and accepts input in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module mul_div_round_saturate (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  mdrs_pkg::req_t      in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output mdrs_pkg::res_t      out_data
);

  // Links between the front end, the cells and the back end. Link 0 is the
  // front end's output, link NUM_CELLS feeds the back end.
  logic               link_valid [mdrs_pkg::NUM_CELLS+1];
  logic               link_ready [mdrs_pkg::NUM_CELLS+1];
  mdrs_pkg::div_tok_t link_tok   [mdrs_pkg::NUM_CELLS+1];

  logic front_ready;

  // The front end masks the operands to the mode width, forms the magnitude
  // of a signed first factor, multiplies, then adds half the divisor for
  // round-to-nearest and checks whether the quotient would exceed 16 bits.
  mdrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .in_data   (in_data),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_tok   (link_tok[0])
  );

  assign in_stall = !front_ready;

  // Restoring divider as a chain of identical cells. Every stage keeps its
  // own valid bit and moves when the next stage is empty or moving, so a
  // stall at the output only fills bubbles and never drops a transfer.
  for (genvar i = 0; i < mdrs_pkg::NUM_CELLS; i++) begin : g_cell
    mdrs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_tok    (link_tok[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_tok   (link_tok[i+1])
    );
  end

  // The back end applies unsigned and signed saturation, restores the sign
  // and handles the zero divisor, then registers the result.
  mdrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (link_valid[mdrs_pkg::NUM_CELLS]),
    .in_ready  (link_ready[mdrs_pkg::NUM_CELLS]),
    .in_tok    (link_tok[mdrs_pkg::NUM_CELLS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A zero divisor always reports all ones in the low byte and no clipping.
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_divisor |->
      (out_data.quotient[7:0] == 8'hFF) && !out_data.clipped)
    else $error("zero divisor result is malformed");

  // Input back-pressure only arises from a stalled result at the output.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
